### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/core/wpdd_pkg.sv
// ----------------------------------------------------------------------------
// wpdd_pkg
// Types and constants for the WAVE PCM16 data chunk downmixer.
// ----------------------------------------------------------------------------
package wpdd_pkg;

    localparam int unsigned MAX_CHANNELS_DEF = 8;
    localparam int unsigned SAMPLE_W         = 16;
    localparam int unsigned QUOT_W           = 16;

    localparam logic [31:0] DATA_ID          = 32'h6174_6164;
    localparam logic [31:0] MIN_FILE_LEN     = 32'd44;
    localparam logic [31:0] CHAN_POS_LO      = 32'd22;
    localparam logic [31:0] CHAN_POS_HI      = 32'd23;
    localparam logic [32:0] FIRST_CHUNK      = 33'd12;
    localparam logic [32:0] MIN_DATA_HDR     = 33'd24;

    localparam logic [1:0]  STATUS_SAMPLE    = 2'd0;
    localparam logic [1:0]  STATUS_END       = 2'd1;
    localparam logic [1:0]  STATUS_LAYOUT    = 2'd2;

    localparam logic [1:0]  PH_SCAN          = 2'd0;
    localparam logic [1:0]  PH_DATA          = 2'd1;
    localparam logic [1:0]  PH_DONE          = 2'd2;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_file;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mono_sample;
        logic [1:0]                 status;
    } out_word_t;

endpackage

### rtl/core/wav_pcm16_data_chunk_downmix.sv
// ----------------------------------------------------------------------------
// wav_pcm16_data_chunk_downmix
// Byte-serial RIFF/WAVE parser that downmixes the PCM16 data chunk to mono.
// ----------------------------------------------------------------------------
// Feed the file one byte per input word, having first written its total
// length to the file_length register while the block is idle. Each byte goes
// through accept, position compare, parse and result; the last byte of a chunk
// header adds one step to decode the header. A byte that completes a frame
// adds the channel mean, found by a shared restoring divider that produces
// one quotient bit per cycle over 16 steps, with a set-up step before them
// and a sign fix after. One result word at most leaves per byte, through
// an output register, so a byte is still taken while an earlier result waits;
// the block only stalls when a second result is ready before the first has
// gone. Status 0 carries a mono sample, 1 reports a file that is too short or
// has no data chunk, 2 reports a data chunk placed before offset 24 or with
// more than MAX_CHANNELS channels. After the final byte (end_of_file high or
// byte file_length-1) the parse state returns to its reset value.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_pcm16_data_chunk_downmix
    import wpdd_pkg::*;
#(
    parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_DEF
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_word_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_word_t   m_data
);

    // Widths that follow from the channel limit
    localparam int unsigned CH_W   = $clog2(MAX_CHANNELS + 1);
    localparam int unsigned SUM_W  = SAMPLE_W + $clog2(MAX_CHANNELS);
    localparam int unsigned NUM_W  = SUM_W + 1;
    localparam int unsigned DEN_W  = $clog2(MAX_CHANNELS) + 2;
    localparam int unsigned HI_W   = NUM_W - QUOT_W;
    localparam int unsigned CNT_W  = $clog2(QUOT_W);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_EXEC = 3'd2;
    localparam logic [2:0] ST_HDR  = 3'd3;
    localparam logic [2:0] ST_DSET = 3'd4;
    localparam logic [2:0] ST_DIV  = 3'd5;
    localparam logic [2:0] ST_DEND = 3'd6;
    localparam logic [2:0] ST_FIN  = 3'd7;

    // Result kinds raised while parsing one byte
    localparam logic [1:0] RES_NONE   = 2'd0;
    localparam logic [1:0] RES_SAMPLE = 2'd1;
    localparam logic [1:0] RES_LAYOUT = 2'd2;

    // Control and parse state
    logic [2:0]              state_reg, state_next;
    logic [31:0]             file_length_reg;
    logic [31:0]             pos_reg, pos_next;
    logic [32:0]             ncs_reg, ncs_next;
    logic [63:0]             hdr_reg, hdr_next;
    logic [15:0]             chan_cnt_reg, chan_cnt_next;
    logic [31:0]             dbl_reg, dbl_next;
    logic [1:0]              phase_reg, phase_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CH_W-1:0]         idx_reg, idx_next;
    logic [7:0]              low_reg, low_next;
    logic                    m_valid_reg, m_valid_next;

    // Per-byte working registers
    logic [7:0]              byte_reg, byte_next;
    logic                    eof_reg, eof_next;
    logic                    last_reg, last_next;
    logic                    in_hdr_reg, in_hdr_next;
    logic [2:0]              k_reg, k_next;
    logic [1:0]              res_reg, res_next;
    out_word_t               m_data_reg, m_data_next;

    // Shared divider
    logic [DEN_W-1:0]        rem_reg, rem_next;
    logic [QUOT_W-1:0]       div_lo_reg, div_lo_next;
    logic [DEN_W-1:0]        den_reg, den_next;
    logic [CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic                    neg_reg, neg_next;
    logic [SAMPLE_W-1:0]     sample_reg, sample_next;

    // Combinational helpers
    logic [15:0]             eff_ch;
    logic [CH_W-1:0]         n_ch;
    logic                    long_file;
    logic [33:0]             pos_diff;
    logic signed [SAMPLE_W-1:0] pcm;
    logic signed [SUM_W-1:0] sum_add;
    logic [SUM_W-1:0]        mag;
    logic [NUM_W-1:0]        num;
    logic [DEN_W:0]          trial;
    logic [31:0]             hdr_id;
    logic [31:0]             hdr_sz;
    logic [33:0]             avail;
    logic [33:0]             nx;
    logic                    emit;

    assign eff_ch    = (chan_cnt_reg == 16'd0) ? 16'd1 : chan_cnt_reg;
    assign n_ch      = eff_ch[CH_W-1:0];
    assign long_file = (file_length_reg >= MIN_FILE_LEN);
    assign pos_diff  = {2'b00, pos_reg} - {1'b0, ncs_reg};
    assign pcm       = $signed({byte_reg, low_reg});
    assign sum_add   = sum_reg + SUM_W'(pcm);
    assign mag       = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign num       = {mag, 1'b0} + NUM_W'(n_ch);
    assign trial     = {rem_reg, div_lo_reg[QUOT_W-1]} - {1'b0, den_reg};
    assign hdr_id    = hdr_reg[31:0];
    assign hdr_sz    = hdr_reg[63:32];
    // Bytes of the file left after the chunk header; negative (bit 33 set) when the header runs past the end
    assign avail     = {2'b00, file_length_reg} - ({1'b0, ncs_reg} + 34'd8);
    // Start of the following chunk: header, body and pad byte
    assign nx        = {1'b0, ncs_reg} + 34'd8 + {2'b00, hdr_sz} + {33'd0, hdr_sz[0]};
    assign emit      = (res_reg inside {RES_SAMPLE, RES_LAYOUT})
                       || (last_reg && (!long_file || phase_reg == PH_SCAN));

    always_comb begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        ncs_next      = ncs_reg;
        hdr_next      = hdr_reg;
        chan_cnt_next = chan_cnt_reg;
        dbl_next      = dbl_reg;
        phase_next    = phase_reg;
        sum_next      = sum_reg;
        idx_next      = idx_reg;
        low_next      = low_reg;
        m_valid_next  = m_valid_reg;
        byte_next     = byte_reg;
        eof_next      = eof_reg;
        last_next     = last_reg;
        in_hdr_next   = in_hdr_reg;
        k_next        = k_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;
        rem_next      = rem_reg;
        div_lo_next   = div_lo_reg;
        den_next      = den_reg;
        div_cnt_next  = div_cnt_reg;
        neg_next      = neg_reg;
        sample_next   = sample_reg;

        // Drop the result word once it has been taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next  = s_data.byte_value;
                    eof_next   = s_data.end_of_file;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                last_next   = eof_reg
                              || (({1'b0, pos_reg} + 33'd1) >= {1'b0, file_length_reg});
                in_hdr_next = (pos_diff[33:3] == 31'd0);
                k_next      = pos_diff[2:0];
                res_next    = RES_NONE;
                if (long_file && pos_reg == CHAN_POS_LO) begin
                    chan_cnt_next[7:0] = byte_reg;
                end
                if (long_file && pos_reg == CHAN_POS_HI) begin
                    chan_cnt_next[15:8] = byte_reg;
                end
                state_next = ST_EXEC;
            end
            ST_EXEC: begin
                state_next = ST_FIN;
                if (long_file) begin
                    if (phase_reg == PH_SCAN) begin
                        if (in_hdr_reg) begin
                            hdr_next[{k_reg, 3'b000} +: 8] = byte_reg;
                            if (k_reg == 3'd7) begin
                                state_next = ST_HDR;
                            end
                        end
                    end else if (phase_reg == PH_DATA && dbl_reg != 32'd0) begin
                        dbl_next = dbl_reg - 32'd1;
                        // Body starts at an even distance from the header
                        if (pos_reg[0] == ncs_reg[0]) begin
                            low_next = byte_reg;
                        end else if ((idx_reg + CH_W'(1)) == n_ch) begin
                            sum_next   = sum_add;
                            state_next = ST_DSET;
                        end else begin
                            sum_next = sum_add;
                            idx_next = idx_reg + CH_W'(1);
                        end
                    end
                end
            end
            ST_HDR: begin
                state_next = ST_FIN;
                if (hdr_id == DATA_ID) begin
                    if (ncs_reg < MIN_DATA_HDR || eff_ch > 16'(MAX_CHANNELS)) begin
                        phase_next = PH_DONE;
                        res_next   = RES_LAYOUT;
                    end else begin
                        if (avail[33]) begin
                            dbl_next = 32'd0;
                        end else if ({2'b00, hdr_sz} < avail) begin
                            dbl_next = hdr_sz;
                        end else begin
                            dbl_next = avail[31:0];
                        end
                        phase_next = PH_DATA;
                        sum_next   = '0;
                        idx_next   = '0;
                    end
                end else begin
                    // Saturate far chunks to an offset that is never reached
                    ncs_next = (nx > 34'h1_0000_0000) ? 33'h1_0000_0000 : nx[32:0];
                end
            end
            ST_DSET: begin
                neg_next     = sum_reg[SUM_W-1];
                rem_next     = {1'b0, num[NUM_W-1 -: HI_W]};
                div_lo_next  = num[QUOT_W-1:0];
                den_next     = DEN_W'({n_ch, 1'b0});
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                if (!trial[DEN_W]) begin
                    rem_next    = trial[DEN_W-1:0];
                    div_lo_next = {div_lo_reg[QUOT_W-2:0], 1'b1};
                end else begin
                    rem_next    = {rem_reg[DEN_W-2:0], div_lo_reg[QUOT_W-1]};
                    div_lo_next = {div_lo_reg[QUOT_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg + CNT_W'(1);
                if (div_cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    state_next = ST_DEND;
                end
            end
            ST_DEND: begin
                sample_next = neg_reg ? (~div_lo_reg + SAMPLE_W'(1)) : div_lo_reg;
                res_next    = RES_SAMPLE;
                sum_next    = '0;
                idx_next    = '0;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                // Hold here while a result must leave and the slot is full
                if (!(emit && m_valid_reg && !m_ready)) begin
                    if (emit) begin
                        m_valid_next = 1'b1;
                        case (res_reg)
                            RES_SAMPLE: begin
                                m_data_next.mono_sample = $signed(sample_reg);
                                m_data_next.status      = STATUS_SAMPLE;
                            end
                            RES_LAYOUT: begin
                                m_data_next.mono_sample = '0;
                                m_data_next.status      = STATUS_LAYOUT;
                            end
                            default: begin
                                m_data_next.mono_sample = '0;
                                m_data_next.status      = STATUS_END;
                            end
                        endcase
                    end
                    if (last_reg) begin
                        pos_next      = '0;
                        ncs_next      = FIRST_CHUNK;
                        hdr_next      = '0;
                        chan_cnt_next = '0;
                        dbl_next      = '0;
                        phase_next    = PH_SCAN;
                        sum_next      = '0;
                        idx_next      = '0;
                        low_next      = '0;
                    end else begin
                        pos_next = pos_reg + 32'd1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            file_length_reg <= '0;
            pos_reg         <= '0;
            ncs_reg         <= FIRST_CHUNK;
            hdr_reg         <= '0;
            chan_cnt_reg    <= '0;
            dbl_reg         <= '0;
            phase_reg       <= PH_SCAN;
            sum_reg         <= '0;
            idx_reg         <= '0;
            low_reg         <= '0;
            m_valid_reg     <= 1'b0;
            res_reg         <= RES_NONE;
        end else begin
            state_reg    <= state_next;
            if (cfg_we) begin
                file_length_reg <= cfg_wdata;
            end
            pos_reg      <= pos_next;
            ncs_reg      <= ncs_next;
            hdr_reg      <= hdr_next;
            chan_cnt_reg <= chan_cnt_next;
            dbl_reg      <= dbl_next;
            phase_reg    <= phase_next;
            sum_reg      <= sum_next;
            idx_reg      <= idx_next;
            low_reg      <= low_next;
            m_valid_reg  <= m_valid_next;
            res_reg      <= res_next;
        end
    end

    // Working and payload registers: no reset needed
    always_ff @(posedge aclk) begin
        byte_reg    <= byte_next;
        eof_reg     <= eof_next;
        last_reg    <= last_next;
        in_hdr_reg  <= in_hdr_next;
        k_reg       <= k_next;
        m_data_reg  <= m_data_next;
        rem_reg     <= rem_next;
        div_lo_reg  <= div_lo_next;
        den_reg     <= den_next;
        div_cnt_reg <= div_cnt_next;
        neg_reg     <= neg_next;
        sample_reg  <= sample_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The data phase is only entered with a supported layout
    `ASSERT_IMPLIES(a_data_ch_limit, aclk, aresetn, phase_reg == PH_DATA, eff_ch <= 16'(MAX_CHANNELS))
    `ASSERT_IMPLIES(a_data_hdr_place, aclk, aresetn, phase_reg == PH_DATA, ncs_reg >= MIN_DATA_HDR)
    // Status words carry a zero sample
    `ASSERT_IMPLIES(a_status_zero, aclk, aresetn, m_valid && m_data.status != STATUS_SAMPLE, m_data.mono_sample == '0)
    // A frame-completing byte always reaches the divider
    `ASSERT_NEXT(a_div_start, aclk, aresetn, state_reg == ST_DSET, state_reg == ST_DIV && div_cnt_reg == '0)

endmodule
